FILE: hdl/half_rgb_reinhard_to_rgba8_defines.svh
// Assertion macros shared by the tonemap pipeline modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef HALF_RGB_REINHARD_TO_RGBA8_DEFINES_SVH
`define HALF_RGB_REINHARD_TO_RGBA8_DEFINES_SVH

// Same-cycle implication
`define RHR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RHR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rhr_pkg.sv
// Constants for the half-float Reinhard tonemap pipeline.
// No dependencies.
`timescale 1ns / 1ps

package rhr_pkg;

    localparam int HALF_W     = 16;
    localparam int EXP_W      = 5;
    localparam int MANT_W     = 10;
    localparam logic [EXP_W-1:0] EXP_MAX = 5'h1F;

    // Magnitude in units of 2^-24: at most 2047 << 29, fits 40 bits
    localparam int N_W        = 40;
    localparam int UNIT_SHIFT = 24;
    // Dividend 511*N + 2^24 and divisor 2^25 + 2*N
    localparam int NUM_W      = 49;
    localparam int DEN_W      = 42;

    localparam int CH_W       = 8;
    localparam logic [CH_W-1:0] CH_MAX = 8'hFF;
    localparam logic [CH_W-1:0] ALPHA  = 8'hFF;

    localparam int BITS_PER_STAGE = 2;

endpackage

FILE: hdl/rhr_chan.sv
// One channel of the tonemap: half decode, dividend/divisor setup and a
// pipelined restoring divider. Depends on rhr_pkg and the defines header.
`timescale 1ns / 1ps
`include "half_rgb_reinhard_to_rgba8_defines.svh"

module rhr_chan #(
    parameter int BITS_PER_STAGE = rhr_pkg::BITS_PER_STAGE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rhr_pkg::HALF_W-1:0]    half_in,
    output logic                          out_valid,
    output logic [rhr_pkg::CH_W-1:0]      q_out
);

    localparam int STAGES = rhr_pkg::CH_W / BITS_PER_STAGE;

    // Decode stage
    logic                       a_valid_reg;
    logic [rhr_pkg::N_W-1:0]    a_n_reg, a_n_next;
    logic                       a_zero_reg, a_zero_next;
    logic                       a_max_reg, a_max_next;

    // Divider stages; index 0 holds the setup
    logic                          d_valid_reg [0:STAGES];
    logic [rhr_pkg::NUM_W-1:0]     d_rem_reg   [0:STAGES];
    logic [rhr_pkg::NUM_W-1:0]     d_rem_next  [0:STAGES];
    logic [rhr_pkg::DEN_W-1:0]     d_den_reg   [0:STAGES];
    logic [rhr_pkg::DEN_W-1:0]     d_den_next  [0:STAGES];
    logic [rhr_pkg::CH_W-1:0]      d_q_reg     [0:STAGES];
    logic [rhr_pkg::CH_W-1:0]      d_q_next    [0:STAGES];
    logic                          d_zero_reg  [0:STAGES];
    logic                          d_max_reg   [0:STAGES];

    // Half decode to magnitude and special flags
    always_comb
    begin
        logic [rhr_pkg::EXP_W-1:0]  e;
        logic [rhr_pkg::MANT_W-1:0] m;
        e = half_in[rhr_pkg::HALF_W-2 -: rhr_pkg::EXP_W];
        m = half_in[rhr_pkg::MANT_W-1:0];
        if (e == '0)
        begin
            a_n_next = rhr_pkg::N_W'(m);
        end
        else
        begin
            a_n_next = rhr_pkg::N_W'({1'b1, m}) << (e - 1'b1);
        end
        // positive infinity is max only; NaN, negatives and zero give 0
        a_max_next  = !half_in[rhr_pkg::HALF_W-1] && (e == rhr_pkg::EXP_MAX) && (m == '0);
        a_zero_next = half_in[rhr_pkg::HALF_W-1] || ((e == rhr_pkg::EXP_MAX) && (m != '0))
                      || ((e == '0) && (m == '0));
    end

    // Setup: dividend 511N + 2^24, divisor 2^25 + 2N
    always_comb
    begin
        d_rem_next[0] = (rhr_pkg::NUM_W'(a_n_reg) << 9) - rhr_pkg::NUM_W'(a_n_reg)
                        + (rhr_pkg::NUM_W'(1) << rhr_pkg::UNIT_SHIFT);
        d_den_next[0] = (rhr_pkg::DEN_W'(1) << (rhr_pkg::UNIT_SHIFT + 1))
                        + (rhr_pkg::DEN_W'(a_n_reg) << 1);
        d_q_next[0]   = '0;
    end

    // Quotient bits, most significant first, BITS_PER_STAGE per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_div
        always_comb
        begin
            logic [rhr_pkg::NUM_W-1:0] rem_v;
            logic [rhr_pkg::NUM_W-1:0] trial_v;
            logic [rhr_pkg::CH_W-1:0]  q_v;
            rem_v = d_rem_reg[k];
            q_v   = d_q_reg[k];
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                trial_v = rhr_pkg::NUM_W'(d_den_reg[k])
                          << (rhr_pkg::CH_W - 1 - BITS_PER_STAGE * k - j);
                if (rem_v >= trial_v)
                begin
                    rem_v = rem_v - trial_v;
                    q_v[rhr_pkg::CH_W - 1 - BITS_PER_STAGE * k - j] = 1'b1;
                end
            end
            d_rem_next[k+1] = rem_v;
            d_q_next[k+1]   = q_v;
            d_den_next[k+1] = d_den_reg[k];
        end
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            for (int s = 0; s <= STAGES; s++)
            begin
                d_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            a_valid_reg    <= in_valid;
            d_valid_reg[0] <= a_valid_reg;
            for (int s = 1; s <= STAGES; s++)
            begin
                d_valid_reg[s] <= d_valid_reg[s-1];
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        a_n_reg       <= a_n_next;
        a_zero_reg    <= a_zero_next;
        a_max_reg     <= a_max_next;
        d_zero_reg[0] <= a_zero_reg;
        d_max_reg[0]  <= a_max_reg;
        for (int s = 0; s <= STAGES; s++)
        begin
            d_rem_reg[s] <= d_rem_next[s];
            d_den_reg[s] <= d_den_next[s];
            d_q_reg[s]   <= d_q_next[s];
        end
        for (int s = 1; s <= STAGES; s++)
        begin
            d_zero_reg[s] <= d_zero_reg[s-1];
            d_max_reg[s]  <= d_max_reg[s-1];
        end
    end

    // Special values override the quotient
    assign out_valid = d_valid_reg[STAGES];
    assign q_out     = d_max_reg[STAGES]  ? rhr_pkg::CH_MAX :
                       d_zero_reg[STAGES] ? '0 : d_q_reg[STAGES];

    `RHR_ASSERT_NOW(a_flags_excl, a_valid_reg, !(a_zero_reg && a_max_reg), "zero and max both set")
    `RHR_ASSERT_NOW(a_rem_bound, d_valid_reg[STAGES],
        d_rem_reg[STAGES] < rhr_pkg::NUM_W'(d_den_reg[STAGES]), "divider remainder not below divisor")
    `RHR_ASSERT_NEXT(a_valid_enter, in_valid, a_valid_reg, "accepted beat not captured")

endmodule

FILE: hdl/half_rgb_reinhard_to_rgba8.sv
// Reinhard tonemap of a binary16 RGB texel to an opaque RGBA8 word, 0xAABBGGRR.
// A beat enters on any cycle with start high; busy never rises, so one texel per clock is
// sustained. Each result appears with done for one cycle, after passing through one
// decode stage, one setup stage, the restoring divider stages and the output register.
// The receiver cannot stall; results must be taken as shown.
// Depends on rhr_pkg, rhr_chan and the defines header.
`timescale 1ns / 1ps
`include "half_rgb_reinhard_to_rgba8_defines.svh"

module half_rgb_reinhard_to_rgba8 #(
    parameter int BITS_PER_STAGE = rhr_pkg::BITS_PER_STAGE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rhr_pkg::HALF_W-1:0]  red_half,
    input  logic [rhr_pkg::HALF_W-1:0]  green_half,
    input  logic [rhr_pkg::HALF_W-1:0]  blue_half,
    output logic                        done,
    output logic [31:0]                 lumel_word
);

    logic                      beat;
    logic                      r_valid, g_valid, b_valid;
    logic [rhr_pkg::CH_W-1:0]  r_q, g_q, b_q;
    logic                      done_reg;
    logic [31:0]               lumel_word_reg, lumel_word_next;

    assign busy = 1'b0;
    assign beat = start && !busy;

    rhr_chan #(.BITS_PER_STAGE(BITS_PER_STAGE)) u_red (
        .clk(clk), .rst_n(rst_n), .in_valid(beat), .half_in(red_half),
        .out_valid(r_valid), .q_out(r_q)
    );

    rhr_chan #(.BITS_PER_STAGE(BITS_PER_STAGE)) u_green (
        .clk(clk), .rst_n(rst_n), .in_valid(beat), .half_in(green_half),
        .out_valid(g_valid), .q_out(g_q)
    );

    rhr_chan #(.BITS_PER_STAGE(BITS_PER_STAGE)) u_blue (
        .clk(clk), .rst_n(rst_n), .in_valid(beat), .half_in(blue_half),
        .out_valid(b_valid), .q_out(b_q)
    );

    // Pack channels with opaque alpha
    assign lumel_word_next = {rhr_pkg::ALPHA, b_q, g_q, r_q};

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lumel_word_reg <= lumel_word_next;
    end

    assign done       = done_reg;
    assign lumel_word = lumel_word_reg;

    `RHR_ASSERT_NOW(a_lanes_aligned, r_valid || g_valid || b_valid,
        r_valid && g_valid && b_valid, "channel lanes out of step")
    `RHR_ASSERT_NEXT(a_done_follows, r_valid, done, "lane result not strobed")
    `RHR_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

FILE: tb/half_rgb_reinhard_to_rgba8_tb.sv
// Testbench for the half-float Reinhard tonemap block: drives binary16 RGB texels and
// checks every RGBA8 word against an in-bench predictor through a small scoreboard.
// Depends on rhr_pkg and the half_rgb_reinhard_to_rgba8 RTL.
`timescale 1ns / 1ps

module half_rgb_reinhard_to_rgba8_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    // Expected tonemapped words, oldest first
    class lumel_scoreboard;
        logic [31:0] pending_words[$];
        int          error_count;

        // Reinhard curve on one binary16 channel, half-up rounding, clamp to 255
        static function logic [7:0] tone_half(logic [15:0] h);
            logic [4:0]  ex;
            logic [9:0]  mant;
            logic [63:0] mag;
            logic [63:0] quo;
            ex   = h[14:10];
            mant = h[9:0];
            if (h[15])
                return 8'd0;
            if (ex == rhr_pkg::EXP_MAX)
                return (mant == 10'd0) ? rhr_pkg::CH_MAX : 8'd0;
            if (ex == 5'd0)
                mag = {54'd0, mant};
            else
                mag = {53'd0, 1'b1, mant} << (ex - 5'd1);
            if (mag == 64'd0)
                return 8'd0;
            quo = (64'd511 * mag + (64'd1 << 24)) / (64'd2 * ((64'd1 << 24) + mag));
            if (quo > 64'd255)
                quo = 64'd255;
            return quo[7:0];
        endfunction

        function void note_texel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            logic [31:0] word;
            word = {rhr_pkg::ALPHA, tone_half(b), tone_half(g), tone_half(r)};
            pending_words = {pending_words, word};
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                error_count++;
                return;
            end
            want = pending_words.pop_front();
            if (got !== want)
            begin
                $display("%0t: lumel_word expected %h actual %h", $time, want, got);
                error_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] red_half;
    logic [15:0] green_half;
    logic [15:0] blue_half;
    logic        done;
    logic [31:0] lumel_word;

    lumel_scoreboard sb;
    int          idle_pct;
    int          quiet_cycles = 0;

    half_rgb_reinhard_to_rgba8 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red_half   (red_half),
        .green_half (green_half),
        .blue_half  (blue_half),
        .done       (done),
        .lumel_word (lumel_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Check results and count cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_word(lumel_word);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n && quiet_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Random binary16 value biased toward interesting classes
    function automatic logic [15:0] pick_half();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 9))
            0: v[14:10] = 5'h1F;
            1: v[14:10] = 5'h00;
            2: v[15] = 1'b0;
            3: v[15:10] = {1'b0, 5'd15 + 5'($urandom_range(0, 2))};
            4: v[15:10] = {1'b0, 5'($urandom_range(5, 25))};
            default: v[15] = ($urandom_range(0, 3) == 0);
        endcase
        return v;
    endfunction

    // One beat: hold start until accepted, then maybe idle
    task automatic send_texel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        start      <= 1'b1;
        red_half   <= r;
        green_half <= g;
        blue_half  <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_texel(r, g, b);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] edge_vals[$];
        sb = new();
        idle_pct = 6;
        rst_n = 1'b0;
        start = 1'b0;
        red_half = '0;
        green_half = '0;
        blue_half = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zeros, negatives, NaN, infinities, subnormals, one, max finite
        edge_vals = '{16'h0000, 16'h8000, 16'hFC00, 16'h7C00, 16'h7E00, 16'hFE01,
                      16'h0001, 16'h03FF, 16'h0400, 16'h3C00, 16'h7BFF, 16'hBC00,
                      16'h3800, 16'h5BF8, 16'h2000, 16'h1C00, 16'h7C01, 16'hFFFF};
        foreach (edge_vals[i])
            send_texel(edge_vals[i], edge_vals[(i + 5) % edge_vals.size()],
                       edge_vals[(i + 11) % edge_vals.size()]);
        send_texel(16'hFFFF, 16'h0000, 16'h5555);
        send_texel(16'hAAAA, 16'hFFFF, 16'h0000);

        // Pause until the pipe is empty
        settle();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 6 : (phase == 1) ? 84 : 0;
            repeat (260)
                send_texel(pick_half(), pick_half(), pick_half());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/rhr_pkg.sv
hdl/rhr_chan.sv
hdl/half_rgb_reinhard_to_rgba8.sv
tb/half_rgb_reinhard_to_rgba8_tb.sv
